FILE: design/pnm_hdr_pkg.sv
// shared types and constants for the pnm header parser
// character codes, status codes and the per-byte result struct; no dependencies
package pnm_hdr_pkg;

	localparam int unsigned NUM_W = 31;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;

	localparam logic [NUM_W-1:0] NUM_LIMIT = 31'd214748354;
	localparam logic [NUM_W-1:0] MAXVAL_OK = 31'd255;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SIGNATURE = 3'd1;
	localparam logic [2:0] ST_SEPARATOR = 3'd2;
	localparam logic [2:0] ST_DIGIT     = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;
	localparam logic [2:0] ST_MAXVAL    = 3'd5;

	localparam logic [1:0] KIND_P4 = 2'd0;

	typedef struct packed {
		logic             emit;
		logic [1:0]       kind;
		logic [NUM_W-1:0] width;
		logic [NUM_W-1:0] height;
		logic [2:0]       status;
	} result_t;

endpackage

FILE: design/pnm_hdr_parse.sv
// parser state machine: holds the header state and decodes one byte per advance
// depends on pnm_hdr_pkg
module pnm_hdr_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           byte_s1,
	output pnm_hdr_pkg::result_t res
);
	import pnm_hdr_pkg::*;

	typedef enum logic [3:0] {
		PH_SIG_P       = 4'd0,
		PH_SIG_KIND    = 4'd1,
		PH_SEP_FIRST   = 4'd2,
		PH_SEP_COMMENT = 4'd3,
		PH_SEP_SKIP    = 4'd4,
		PH_NUM_FIRST   = 4'd5,
		PH_NUM_COMMENT = 4'd6,
		PH_NUM_AFTERC  = 4'd7,
		PH_NUM_DIGITS  = 4'd8
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [1:0]       sub_q, sub_n;
	logic [1:0]       kind_q, kind_n;
	logic [NUM_W-1:0] acc_q, acc_n;
	logic [NUM_W-1:0] width_q, width_n;
	logic [NUM_W-1:0] height_q, height_n;

	logic             is_space, is_nl, is_digit, is_hash;
	logic [NUM_W-1:0] acc_base;
	logic [NUM_W+2:0] acc_x10;
	logic [NUM_W-1:0] acc_step;
	logic             ovf;
	logic             fin;
	logic [2:0]       status;

	assign is_nl    = (byte_s1 == CH_LF) || (byte_s1 == CH_CR);
	assign is_space = is_nl || (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);
	assign is_digit = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
	assign is_hash  = (byte_s1 == CH_HASH);

	// a number entered from whitespace skip starts from zero
	assign acc_base = (phase_q == PH_SEP_SKIP) ? '0 : acc_q;
	assign ovf      = acc_base > NUM_LIMIT;
	assign acc_x10  = ({3'b000, acc_base} << 3) + ({3'b000, acc_base} << 1);
	assign acc_step = acc_x10[NUM_W-1:0] + {{(NUM_W-4){1'b0}}, byte_s1[3:0]};

	always_comb begin
		phase_n  = phase_q;
		sub_n    = sub_q;
		kind_n   = kind_q;
		acc_n    = acc_q;
		width_n  = width_q;
		height_n = height_q;
		fin      = 1'b0;
		status   = ST_OK;
		unique case (phase_q) inside
			PH_SIG_KIND: begin
				if ((byte_s1 < CH_4) || (byte_s1 > CH_6)) begin
					fin    = 1'b1;
					status = ST_SIGNATURE;
				end else begin
					kind_n  = byte_s1[1:0];
					phase_n = PH_SEP_FIRST;
				end
			end
			PH_SEP_FIRST: begin
				if (is_hash) begin
					phase_n = PH_SEP_COMMENT;
				end else if (is_space) begin
					phase_n = PH_SEP_SKIP;
				end else begin
					fin    = 1'b1;
					status = ST_SEPARATOR;
				end
			end
			PH_SEP_COMMENT: begin
				if (is_nl) phase_n = PH_SEP_SKIP;
			end
			PH_SEP_SKIP, PH_NUM_FIRST: begin
				if (phase_q == PH_SEP_SKIP && is_space) begin
					phase_n = PH_SEP_SKIP;
				end else if (is_hash) begin
					acc_n   = acc_base;
					phase_n = PH_NUM_COMMENT;
				end else if (!is_digit) begin
					fin    = 1'b1;
					status = ST_DIGIT;
				end else if (ovf) begin
					fin    = 1'b1;
					status = ST_TOO_LARGE;
				end else begin
					acc_n   = acc_step;
					phase_n = PH_NUM_DIGITS;
				end
			end
			PH_NUM_COMMENT: begin
				if (is_nl) phase_n = PH_NUM_AFTERC;
			end
			PH_NUM_AFTERC: begin
				if (!is_digit) begin
					fin    = 1'b1;
					status = ST_DIGIT;
				end else if (ovf) begin
					fin    = 1'b1;
					status = ST_TOO_LARGE;
				end else begin
					acc_n   = acc_step;
					phase_n = PH_NUM_DIGITS;
				end
			end
			PH_NUM_DIGITS: begin
				if (is_digit) begin
					if (ovf) begin
						fin    = 1'b1;
						status = ST_TOO_LARGE;
					end else begin
						acc_n = acc_step;
					end
				end else if (sub_q == 2'd0 || (sub_q == 2'd1 && kind_q != KIND_P4)) begin
					// ending byte doubles as the first separator byte
					if (sub_q == 2'd0) width_n = acc_q;
					else height_n = acc_q;
					sub_n = sub_q + 2'd1;
					if (is_hash) begin
						phase_n = PH_SEP_COMMENT;
					end else if (is_space) begin
						phase_n = PH_SEP_SKIP;
					end else begin
						fin    = 1'b1;
						status = ST_SEPARATOR;
					end
				end else if (sub_q == 2'd1) begin
					height_n = acc_q;
					fin      = 1'b1;
				end else begin
					fin    = 1'b1;
					status = (acc_q == MAXVAL_OK) ? ST_OK : ST_MAXVAL;
				end
			end
			default: begin
				if (byte_s1 == CH_P) begin
					phase_n = PH_SIG_KIND;
				end else begin
					fin    = 1'b1;
					status = ST_SIGNATURE;
				end
			end
		endcase
	end

	always_comb begin
		res.emit   = fin;
		res.status = status;
		if (status == ST_OK) begin
			res.kind   = kind_q;
			res.width  = width_n;
			res.height = height_n;
		end else begin
			res.kind   = '0;
			res.width  = '0;
			res.height = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG_P;
			sub_q    <= '0;
			kind_q   <= '0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (advance) begin
			if (fin) begin
				phase_q  <= PH_SIG_P;
				sub_q    <= '0;
				kind_q   <= '0;
				acc_q    <= '0;
				width_q  <= '0;
				height_q <= '0;
			end else begin
				phase_q  <= phase_n;
				sub_q    <= sub_n;
				kind_q   <= kind_n;
				acc_q    <= acc_n;
				width_q  <= width_n;
				height_q <= height_n;
			end
		end
	end

endmodule

FILE: design/pnm_header_parser.sv
// top level of the pnm header parser: input register, parser, result register
// depends on pnm_hdr_pkg and pnm_hdr_parse
//
//  channel  | valid / stall                | payload
//  ---------+------------------------------+---------------------------------------
//  header   | header_valid / header_stall  | header_byte
//  result   | result_valid / result_stall  | image_kind, image_width, image_height,
//           |                              | parse_status
//
// one byte per cycle while header_stall is low; each byte is decoded from the
// input register and its result, if any, is shown from the result register
// the parser state advances only when the result register can take a new result
// reset clears the parser to awaiting the signature letter and empties both registers
module pnm_header_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          header_valid,
	output logic                          header_stall,
	input  logic [7:0]                    header_byte,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    image_kind,
	output logic [pnm_hdr_pkg::NUM_W-1:0] image_width,
	output logic [pnm_hdr_pkg::NUM_W-1:0] image_height,
	output logic [2:0]                    parse_status
);
	import pnm_hdr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       take_in;
	result_t    res;

	assign advance      = valid_s1 && !(result_valid && result_stall);
	assign header_stall = valid_s1 && result_valid && result_stall;
	assign take_in      = header_valid && !header_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) byte_s1 <= header_byte;
	end

	pnm_hdr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res.emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			image_kind   <= res.kind;
			image_width  <= res.width;
			image_height <= res.height;
			parse_status <= res.status;
		end
	end

endmodule
